// ===== hdl/lfu_pkg.sv =====
// shared constants, codes and types of the lfu cache table
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 32;
  localparam int DATA_W     = 32;
  localparam int CAP_W      = 5;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [DATA_W-1:0]     READ_MISS = {DATA_W{1'b1}};

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HIT_UPD,
    ST_SWEEP,
    ST_INSERT,
    ST_FINISH
  } lfu_state_e;

  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_TOUCH,
    CELL_INSERT
  } cell_op_e;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_e                op;
    logic                    put;
    logic [IDX_W-1:0]        tgt_idx;
    logic [IDX_W-1:0]        tgt_rank;
    logic                    evict;
    logic                    slot_en;
    logic [IDX_W-1:0]        slot_idx;
    logic [DATA_W-1:0]       wr_key;
    logic [DATA_W-1:0]       wr_data;
  } cell_cmd_t;

  // running victim and free slot search handed down the chain
  typedef struct packed {
    logic                    has_victim;
    logic [IDX_W-1:0]        v_idx;
    logic [COUNT_BITS-1:0]   v_count;
    logic [IDX_W-1:0]        v_rank;
    logic [DATA_W-1:0]       v_key;
    logic                    has_free;
    logic [IDX_W-1:0]        free_idx;
  } sweep_t;

endpackage

// ===== hdl/lfu_in_if.sv =====
// request channel: op, key and value words
interface lfu_in_if;
  import lfu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, key, value, input ready);
  modport sink   (input valid, op, key, value, output ready);
endinterface

// ===== hdl/lfu_out_if.sv =====
// response channel: hit, read value and eviction words
interface lfu_out_if;
  import lfu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  logic                     evicted;
  logic signed [DATA_W-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== hdl/lfu_cell.sv =====
// one cache entry with its share of the victim search chain
module lfu_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lfu_pkg::IDX_W-1:0]      cell_idx_i,
  input  lfu_pkg::cell_cmd_t             cmd_i,
  input  logic [lfu_pkg::DATA_W-1:0]     req_key_i,
  input  lfu_pkg::sweep_t                sweep_i,
  output lfu_pkg::sweep_t                sweep_o,
  output logic                           hit_o,
  output logic [lfu_pkg::DATA_W-1:0]     data_o,
  output logic [lfu_pkg::IDX_W-1:0]      rank_o
);
  import lfu_pkg::*;

  logic                  valid_q, valid_d;
  logic [DATA_W-1:0]     key_q, key_d;
  logic [DATA_W-1:0]     data_q, data_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [IDX_W-1:0]      rank_q, rank_d;
  sweep_t                sweep_q, sweep_d;
  logic                  is_tgt, is_slot, better;

  assign is_tgt  = (cell_idx_i == cmd_i.tgt_idx);
  assign is_slot = cmd_i.slot_en && (cell_idx_i == cmd_i.slot_idx);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    count_d = count_q;
    rank_d  = rank_q;
    case (cmd_i.op)
      CELL_TOUCH: begin
        if (is_tgt) begin
          if (cmd_i.put) begin
            data_d = cmd_i.wr_data;
          end
          if (count_q != COUNT_MAX) begin
            count_d = count_q + COUNT_BITS'(1);
          end
          rank_d = '0;
        end else if (valid_q && (rank_q < cmd_i.tgt_rank)) begin
          rank_d = rank_q + IDX_W'(1);
        end
      end
      CELL_INSERT: begin
        if (is_slot) begin
          valid_d = 1'b1;
          key_d   = cmd_i.wr_key;
          data_d  = cmd_i.wr_data;
          count_d = COUNT_BITS'(1);
          rank_d  = '0;
        end else if (cmd_i.slot_en && cmd_i.evict && is_tgt) begin
          valid_d = 1'b0;
        end else if (cmd_i.slot_en && valid_q) begin
          // older than the victim: one down for the drop, one up for the insert
          if (!(cmd_i.evict && (rank_q > cmd_i.tgt_rank))) begin
            rank_d = rank_q + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // this entry beats the candidate from upstream
  assign better = valid_q && (!sweep_i.has_victim || (count_q < sweep_i.v_count) ||
                  ((count_q == sweep_i.v_count) && (rank_q > sweep_i.v_rank)));

  always_comb begin
    sweep_d = sweep_i;
    if (better) begin
      sweep_d.has_victim = 1'b1;
      sweep_d.v_idx      = cell_idx_i;
      sweep_d.v_count    = count_q;
      sweep_d.v_rank     = rank_q;
      sweep_d.v_key      = key_q;
    end
    if (!sweep_i.has_free && !valid_q) begin
      sweep_d.has_free = 1'b1;
      sweep_d.free_idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sweep_q <= '0;
    end else begin
      valid_q <= valid_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    data_q  <= data_d;
    count_q <= count_d;
    rank_q  <= rank_d;
  end

  assign sweep_o = sweep_q;
  assign hit_o   = valid_q && (key_q == req_key_i);
  assign data_o  = data_q;
  assign rank_o  = rank_q;

endmodule

// ===== hdl/lfu_cache_table.sv =====
// top level of the lfu cache table: control sequencer over a row of entry cells
// Fully associative key/value cache, ENTRIES entries, least-frequently-used
// replacement with ties going to the least recently used entry. Each request
// word (op, key, value) yields exactly one response word. The block works on
// one request at a time but takes the next request while a response still
// waits on the output register. A put of a new key waits for the victim
// search, which travels one cell per cycle down the chain of entry cells,
// each cell registering the best (count, oldest) candidate so far and the
// lowest free slot. Capacity is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Values above ENTRIES act as ENTRIES, and zero makes
// gets miss and puts do nothing while keeping stored entries.
module lfu_cache_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata_i,
  lfu_in_if.sink                    in_if,
  lfu_out_if.source                 out_if
);
  import lfu_pkg::*;

  lfu_state_e state_q, state_d;

  // request word
  logic              req_op_q;
  logic [DATA_W-1:0] req_key_q;
  logic [DATA_W-1:0] req_value_q;

  // lookup outcome
  logic [IDX_W-1:0]  found_idx_q;
  logic [IDX_W-1:0]  found_rank_q;
  logic              need_evict_q;

  // victim search outcome
  sweep_t            vic_q;
  logic [IDX_W-1:0]  sweep_cnt_q, sweep_cnt_d;

  // response held until it moves to the output register
  logic              res_hit_q;
  logic [DATA_W-1:0] res_rv_q;
  logic              res_ev_q;
  logic [DATA_W-1:0] res_ek_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q;
  logic [DATA_W-1:0] out_rv_q;
  logic              out_ev_q;
  logic [DATA_W-1:0] out_ek_q;

  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  entry_count_q, entry_count_d;

  // cell row
  cell_cmd_t         cmd;
  sweep_t            sweep_w [ENTRIES+1];
  logic              hit_w   [ENTRIES];
  logic [DATA_W-1:0] data_w  [ENTRIES];
  logic [IDX_W-1:0]  rank_w  [ENTRIES];

  // key match gathered over the row
  logic              any_hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  hit_rank;
  logic [DATA_W-1:0] hit_data;

  logic [CMP_W-1:0]  cap_eff;
  logic              cap_zero;
  logic              in_fire;
  logic              out_load;
  logic              sweep_last;
  logic              do_evict;
  logic              slot_en;
  logic [IDX_W-1:0]  slot_idx;

  assign sweep_w[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .cmd_i      (cmd),
      .req_key_i  (req_key_q),
      .sweep_i    (sweep_w[g]),
      .sweep_o    (sweep_w[g+1]),
      .hit_o      (hit_w[g]),
      .data_o     (data_w[g]),
      .rank_o     (rank_w[g])
    );
  end

  // keys are unique among valid entries, so an or-mux picks the match
  always_comb begin
    any_hit  = 1'b0;
    hit_idx  = '0;
    hit_rank = '0;
    hit_data = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (hit_w[j]) begin
        any_hit  = 1'b1;
        hit_idx  = hit_idx | IDX_W'(j);
        hit_rank = hit_rank | rank_w[j];
        hit_data = hit_data | data_w[j];
      end
    end
  end

  // capacity above the table size acts as the table size
  assign cap_eff  = (CMP_W'(cap_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_q);
  assign cap_zero = (cap_eff == '0);

  assign in_fire    = in_if.valid && in_if.ready;
  assign sweep_last = (sweep_cnt_q == IDX_W'(ENTRIES - 1));
  assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_if.ready);

  // slot for the new key: lowest free entry once the victim has gone
  assign do_evict = need_evict_q && vic_q.has_victim;
  always_comb begin
    slot_en  = vic_q.has_free;
    slot_idx = vic_q.free_idx;
    if (do_evict) begin
      slot_en = 1'b1;
      if (!(vic_q.has_free && (vic_q.free_idx < vic_q.v_idx))) begin
        slot_idx = vic_q.v_idx;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (cap_zero) begin
          state_d = ST_FINISH;
        end else if (any_hit) begin
          state_d = ST_HIT_UPD;
        end else if (req_op_q == OP_GET) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_HIT_UPD: state_d = ST_FINISH;
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: ready and the cell command
  always_comb begin
    in_if.ready  = 1'b0;
    cmd          = '0;
    cmd.op       = CELL_NOP;
    cmd.put      = req_op_q;
    cmd.wr_key   = req_key_q;
    cmd.wr_data  = req_value_q;
    unique case (state_q)
      ST_IDLE: in_if.ready = 1'b1;
      ST_HIT_UPD: begin
        cmd.op       = CELL_TOUCH;
        cmd.tgt_idx  = found_idx_q;
        cmd.tgt_rank = found_rank_q;
      end
      ST_INSERT: begin
        cmd.op       = CELL_INSERT;
        cmd.tgt_idx  = vic_q.v_idx;
        cmd.tgt_rank = vic_q.v_rank;
        cmd.evict    = do_evict;
        cmd.slot_en  = slot_en;
        cmd.slot_idx = slot_idx;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sweep_cnt_d = '0;
    if (state_q == ST_SWEEP) begin
      sweep_cnt_d = sweep_cnt_q + IDX_W'(1);
    end
  end

  // an eviction keeps the count, a plain insert raises it
  always_comb begin
    entry_count_d = entry_count_q;
    if ((state_q == ST_INSERT) && !do_evict && slot_en) begin
      entry_count_d = entry_count_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sweep_cnt_q   <= '0;
      out_valid_q   <= 1'b0;
      cap_q         <= CAP_RESET;
      entry_count_q <= '0;
    end else begin
      state_q       <= state_d;
      sweep_cnt_q   <= sweep_cnt_d;
      out_valid_q   <= out_valid_d;
      entry_count_q <= entry_count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_op_q    <= in_if.op;
      req_key_q   <= in_if.key;
      req_value_q <= in_if.value;
    end
    if (state_q == ST_LOOKUP) begin
      found_idx_q  <= hit_idx;
      found_rank_q <= hit_rank;
      need_evict_q <= (CMP_W'(entry_count_q) >= cap_eff);
      res_hit_q    <= any_hit && !cap_zero;
      res_ev_q     <= 1'b0;
      res_ek_q     <= '0;
      if (req_op_q == OP_PUT) begin
        res_rv_q <= '0;
      end else if (any_hit && !cap_zero) begin
        res_rv_q <= hit_data;
      end else begin
        res_rv_q <= READ_MISS;
      end
    end
    if ((state_q == ST_SWEEP) && sweep_last) begin
      vic_q <= sweep_w[ENTRIES];
    end
    if (state_q == ST_INSERT) begin
      res_ev_q <= do_evict;
      res_ek_q <= do_evict ? vic_q.v_key : '0;
    end
    if (out_load) begin
      out_hit_q <= res_hit_q;
      out_rv_q  <= res_rv_q;
      out_ev_q  <= res_ev_q;
      out_ek_q  <= res_ek_q;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.hit         = out_hit_q;
  assign out_if.read_value  = out_rv_q;
  assign out_if.evicted     = out_ev_q;
  assign out_if.evicted_key = out_ek_q;

endmodule

// ===== hdl/lfu_checker.sv =====
// port-level checks on the lfu cache table and the bind that attaches them
module lfu_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [lfu_pkg::CAP_W-1:0] cfg_wdata_i,
  lfu_in_if.sink                   in_if,
  lfu_out_if.source                out_if
);
  import lfu_pkg::*;

  logic [1:0] pending_q;
  logic       cap_zero_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      cap_zero_q <= 1'b0;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (cfg_we_i) begin
        cap_zero_q <= (cfg_wdata_i == '0);
      end
    end
  end

  // a stalled response word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.hit) &&
    $stable(out_if.read_value) && $stable(out_if.evicted) && $stable(out_if.evicted_key))
    else $error("response word changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_if.ready)
    else $error("request taken while the previous one is in work");

  // no response without a request behind it
  a_no_extra_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> pending_q != 2'd0)
    else $error("response without an outstanding request");

  // a disabled cache neither hits nor evicts
  a_cap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && cap_zero_q |-> !out_if.hit && !out_if.evicted)
    else $error("hit or eviction with capacity zero");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_if       (in_if),
  .out_if      (out_if)
);

// ===== bench/lfu_reply_checker.sv =====
// reply checker for the lfu cache table: tracks capacity writes, predicts and compares reply words
module lfu_reply_checker
  import lfu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  lfu_in_if                req_if,
  lfu_out_if               rsp_if,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } reply_t;

  // shadow copy of the cache
  logic [CAP_W-1:0]      capacity;
  logic                  ent_valid [ENTRIES];
  logic [DATA_W-1:0]     ent_key   [ENTRIES];
  logic [DATA_W-1:0]     ent_data  [ENTRIES];
  logic [COUNT_BITS-1:0] ent_uses  [ENTRIES];
  logic [IDX_W-1:0]      ent_age   [ENTRIES];
  int                    held;

  reply_t replies_due [$];
  int     mismatches;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h want %h", $time, what, got, want);
  endtask

  // hit: bump count (saturating) and move to the front of the recency order
  task automatic touch_entry(input int i);
    for (int j = 0; j < ENTRIES; j++)
      if (ent_valid[j] && ent_age[j] < ent_age[i]) ent_age[j]++;
    ent_age[i] = '0;
    if (ent_uses[i] != COUNT_MAX) ent_uses[i]++;
  endtask

  task automatic cache_access(input logic op, input logic [DATA_W-1:0] key,
                              input logic [DATA_W-1:0] val, output reply_t r);
    int lim;
    int found;
    int victim;
    int slot;
    r = '0;
    lim = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
    found = -1;
    victim = -1;
    slot = -1;
    if (lim == 0) begin
      if (op == OP_GET) r.read_value = READ_MISS;
    end else begin
      for (int i = 0; i < ENTRIES; i++)
        if (found < 0 && ent_valid[i] && ent_key[i] == key) found = i;
      if (found >= 0) begin
        r.hit = 1'b1;
        if (op == OP_GET) r.read_value = ent_data[found];
        else ent_data[found] = val;
        touch_entry(found);
      end else if (op == OP_GET) begin
        r.read_value = READ_MISS;
      end else begin
        if (held >= lim) begin
          // lowest count, oldest on a tie
          for (int i = 0; i < ENTRIES; i++)
            if (ent_valid[i] && (victim < 0 || ent_uses[i] < ent_uses[victim] ||
                (ent_uses[i] == ent_uses[victim] && ent_age[i] > ent_age[victim])))
              victim = i;
          if (victim >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = ent_key[victim];
            for (int j = 0; j < ENTRIES; j++)
              if (ent_valid[j] && ent_age[j] > ent_age[victim]) ent_age[j]--;
            ent_valid[victim] = 1'b0;
            if (held > 0) held--;
          end
        end
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !ent_valid[i]) slot = i;
        if (slot >= 0) begin
          for (int j = 0; j < ENTRIES; j++)
            if (ent_valid[j]) ent_age[j]++;
          ent_valid[slot] = 1'b1;
          ent_key[slot] = key;
          ent_data[slot] = val;
          ent_uses[slot] = 1;
          ent_age[slot] = '0;
          held++;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      capacity = CAP_RESET;
      held = 0;
      mismatches = 0;
      for (int i = 0; i < ENTRIES; i++) ent_valid[i] = 1'b0;
      replies_due.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      // compare before predicting: a reply never belongs to a word taken at the same edge
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.hit, rsp_if.read_value, rsp_if.evicted, rsp_if.evicted_key};
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply word", got.read_value, '0);
        end else begin
          want = replies_due.pop_front();
          if (got.hit !== want.hit)
            report_mismatch("hit", DATA_W'(got.hit), DATA_W'(want.hit));
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.evicted !== want.evicted)
            report_mismatch("evicted", DATA_W'(got.evicted), DATA_W'(want.evicted));
          if (got.evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
        end
      end
      if (req_if.valid && req_if.ready) begin
        cache_access(req_if.op, req_if.key, req_if.value, want);
        replies_due.push_back(want);
      end
      fail_count_o <= mismatches;
      pending_o <= replies_due.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// testbench top of the lfu cache table: clock, reset, stimulus, reply stalls and verdict
module tb;
  import lfu_pkg::*;

  // run limit in cycles; the slowest legal run is roughly 700 words, each
  // held up by the victim search of the block, sender gaps and receiver stalls
  localparam int RUN_LIMIT = 400000;
  localparam int SEGMENTS  = 9;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending;
  int               cycles = 0;

  // idle percentages of the two sides, changed per phase
  int send_idle_pct = 23;
  int recv_idle_pct = 66;

  lfu_in_if  req_bus ();
  lfu_out_if rsp_bus ();

  lfu_cache_table u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (req_bus),
    .out_if      (rsp_bus)
  );

  lfu_reply_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_if       (req_bus),
    .rsp_if       (rsp_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls at random at the current rate
  always @(posedge clk) begin
    rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // offer one request word, with a random gap first, and hold it until taken;
  // valid stays high on return so back-to-back words need no second assignment
  task automatic send_word(input logic op, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.op    <= op;
    req_bus.key   <= key;
    req_bus.value <= val;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
  endtask

  // stop sending and wait until every predicted reply has come back
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // capacity is only written with the block idle
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0]  seg_cap [SEGMENTS];
    logic [DATA_W-1:0] key_pool [24];
    logic [DATA_W-1:0] k;
    int                eff_cap;
    int                pool_n;
    int                hot_n;
    int                seg_len;
    int                pick;

    seg_cap = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd9, 5'd2, 5'd16, 5'd12};

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    req_bus.valid <= 1'b0;
    req_bus.op    <= OP_GET;
    req_bus.key   <= '0;
    req_bus.value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, reset capacity of 16 ----
    send_word(OP_GET, 32'h0000_0000, 32'h1234_5678);  // lookup in an empty cache
    send_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);  // extreme keys and values
    send_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);  // hits raise the count
    send_word(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(OP_PUT, 32'hFFFF_FFFF, 32'h5555_AAAA);  // put to a present key updates
    send_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);

    // capacity lowered below what is held: one eviction per new key, count stays
    set_capacity(5'd2);
    send_word(OP_PUT, 32'h0000_0123, 32'hAAAA_5555);
    send_word(OP_PUT, 32'h0000_0456, 32'h0F0F_F0F0);
    send_word(OP_GET, 32'h0000_0123, 32'h0000_0000);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);

    // disabled cache: gets miss, puts do nothing, contents survive
    set_capacity(5'd0);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(OP_PUT, 32'h0000_0789, 32'h0000_0001);

    // capacity above the table size acts as the full table
    set_capacity(5'd31);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(OP_GET, 32'h0000_0789, 32'h0000_0000);

    // single entry: equal counts go to the least recent
    set_capacity(5'd1);
    send_word(OP_PUT, 32'h0000_0AAA, 32'h0000_0003);
    send_word(OP_PUT, 32'h0000_0BBB, 32'h0000_0004);
    send_word(OP_GET, 32'h0000_0BBB, 32'h0000_0000);

    // ---- random part: one capacity per segment ----
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // sender 23 / receiver 66, then swapped, then no idling
      if (seg < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 66;
      end else if (seg < 6) begin
        send_idle_pct = 66;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_capacity(seg_cap[seg]);

      // key pool a little larger than the capacity keeps hits and evictions
      // both common; the first quarter is hot so use counts spread out
      eff_cap = (seg_cap[seg] > ENTRIES) ? ENTRIES : int'(seg_cap[seg]);
      pool_n  = eff_cap + 2 + $urandom_range(0, 5);
      if (pool_n > 24) pool_n = 24;
      if (pool_n < 4) pool_n = 4;
      hot_n = (pool_n / 4 > 0) ? pool_n / 4 : 1;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'hFFFF_FFFF;
      key_pool[3] = 32'h0000_0000;
      for (int i = 4; i < 24; i++) key_pool[i] = $urandom();

      // a disabled cache only answers misses, so keep that segment short
      seg_len = (seg_cap[seg] == 0) ? 20 : 78;
      for (int n = 0; n < seg_len; n++) begin
        // let the pipeline run dry mid-segment now and then
        if (seg % 2 == 1 && n == seg_len / 2) drain();
        pick = $urandom_range(0, 99);
        if (pick < 5) k = $urandom();
        else if (pick < 50) k = key_pool[$urandom_range(0, hot_n - 1)];
        else k = key_pool[$urandom_range(0, pool_n - 1)];
        send_word(1'($urandom_range(0, 1)), k, $urandom());
      end
    end

    // everything sent: wait for the last replies, then watch for strays
    drain();
    repeat (ENTRIES + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lfu_pkg.sv
hdl/lfu_in_if.sv
hdl/lfu_out_if.sv
hdl/lfu_cell.sv
hdl/lfu_cache_table.sv
hdl/lfu_checker.sv
bench/lfu_reply_checker.sv
bench/tb.sv
